@@ rtl/ucc_pkg.sv @@
// shared types, character codes and digit helpers for the clock command console
`default_nettype none

package ucc_pkg;

  // line buffer limits
  localparam int unsigned LineLimitDefault = 128;
  localparam int unsigned HeadDepth        = 7;
  localparam int unsigned HeadIdxW         = $clog2(HeadDepth);
  localparam int unsigned NumValues        = 3;

  // character codes
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSet   = 8'h31;
  localparam logic [7:0] CharGet   = 8'h32;
  localparam logic [7:0] CharPrmpt = 8'h3E;
  localparam logic [7:0] CharSpace = 8'h20;

  // command decoded from the head of a finished line
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_GET,
    CMD_SET
  } cmd_e;

  // one accepted request, ready for output sequencing
  typedef struct packed {
    logic [7:0]                 ch;
    logic                       cr;
    cmd_e                       cmd;
    logic [NumValues-1:0][7:0]  val;
  } job_t;

  // tens digit of an 8-bit value by reciprocal multiply (exact below 256)
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [18:0] p;
    p = 19'(v) * 19'd205;
    return p[15:11];
  endfunction

  // units digit of an 8-bit value given its tens digit
  function automatic logic [3:0] mod10(input logic [7:0] v, input logic [4:0] q);
    logic [7:0] t;
    t = v - 8'(q) * 8'd10;
    return t[3:0];
  endfunction

  // two-character decimal field, wrapping at 256
  function automatic logic [7:0] parse_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] a;
    a = hi - CharZero;
    return 8'(a * 8'd10) + lo - CharZero;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ucc_line.sv @@
// line buffer, line count and command decode for each received byte
`default_nettype none

module ucc_line #(
  parameter int unsigned LINE_LIMIT = ucc_pkg::LineLimitDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic [4:0]   cur_hour_i,
  input  wire logic [5:0]   cur_minute_i,
  input  wire logic [5:0]   cur_second_i,
  output ucc_pkg::job_t     job_o
);

  logic [7:0] line_count_q, line_count_d;
  logic [7:0] count_inc;
  logic       store_head;
  logic [7:0] head_q [ucc_pkg::HeadDepth];
  logic [7:0] head_n [ucc_pkg::HeadDepth];
  logic       is_cr;

  // head contents as they stand after this byte is stored
  assign store_head = line_count_q < 8'(ucc_pkg::HeadDepth);
  always_comb begin
    for (int i = 0; i < int'(ucc_pkg::HeadDepth); i++) begin
      head_n[i] = (store_head && line_count_q[ucc_pkg::HeadIdxW-1:0] ==
                   ucc_pkg::HeadIdxW'(i)) ? rx_byte_i : head_q[i];
    end
  end

  // saturating count, cleared at end of line
  assign is_cr        = rx_byte_i == ucc_pkg::CharCr;
  assign count_inc    = (line_count_q < 8'(LINE_LIMIT)) ? line_count_q + 8'd1 : line_count_q;
  assign line_count_d = is_cr ? 8'd0 : count_inc;

  // command decode and field values
  always_comb begin
    job_o.ch  = rx_byte_i;
    job_o.cr  = is_cr;
    job_o.cmd = ucc_pkg::CMD_NONE;
    job_o.val[0] = {3'b000, cur_hour_i};
    job_o.val[1] = {2'b00, cur_minute_i};
    job_o.val[2] = {2'b00, cur_second_i};
    if (is_cr) begin
      if (head_n[0] == ucc_pkg::CharGet) begin
        job_o.cmd = ucc_pkg::CMD_GET;
      end else if (head_n[0] == ucc_pkg::CharSet &&
                   count_inc >= 8'(ucc_pkg::HeadDepth)) begin
        job_o.cmd    = ucc_pkg::CMD_SET;
        job_o.val[0] = ucc_pkg::parse_pair(head_n[1], head_n[2]);
        job_o.val[1] = ucc_pkg::parse_pair(head_n[3], head_n[4]);
        job_o.val[2] = ucc_pkg::parse_pair(head_n[5], head_n[6]);
      end
    end
  end

  // line count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= 8'd0;
    end else if (accept_i) begin
      line_count_q <= line_count_d;
    end
  end

  // head storage, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (accept_i && store_head) begin
      head_q[line_count_q[ucc_pkg::HeadIdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uart_clock_command_console.sv @@
// Serial console for a real-time clock: echo, time query and time set commands.
//
// Input stream (s_axis): one received character with the current clock time
// per request. Output stream (m_axis): characters to transmit, one per request;
// tlast marks the final character caused by an input, tuser marks the echo of
// a set command that writes the clock, with the new values in tdata.
// An ordinary byte gives 1 character, a carriage return gives 5, and a
// carriage return ending a query or set line gives 12.
// An accepted input sits in the job register; its characters are then loaded
// into the output register, from which the receiver takes them. Characters
// leave one per cycle while the receiver does not stall, and plain echoes
// flow back to back at one per cycle while m_axis_tready stays high. The output
// sequencer, one character a cycle, sets this rate.
// Reset clears the line count and all valid flags; the line buffer is not
// cleared. When the receiver stalls, the output register holds its character
// and the job register holds the pending request. s_axis_tready stays low
// while the job register holds a request whose last character has not yet
// moved into the output register.
`default_nettype none

module uart_clock_command_console #(
  parameter int unsigned LINE_LIMIT = ucc_pkg::LineLimitDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // rx_byte[7:0], cur_hour[12:8], cur_minute[18:13], cur_second[24:19], zero pad
  input  wire logic [31:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_byte[7:0], new_hour[15:8], new_minute[23:16], new_second[31:24]
  output      logic [31:0] m_axis_tdata,
  output      logic        m_axis_tlast,
  // time_write[0]
  output      logic        m_axis_tuser
);

  logic          in_accept;
  ucc_pkg::job_t job_new;
  ucc_pkg::job_t job_q;
  logic          job_valid_q;
  logic [3:0]    idx_q;
  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic          out_last_q;
  logic          out_user_q;
  logic          out_load;
  logic          has_cmd;
  logic [3:0]    last_idx;
  logic          is_last;
  logic          job_done;
  logic [1:0]    tail_pos;
  logic [7:0]    sel_val;
  logic [4:0]    tens;
  logic [3:0]    units;
  logic [7:0]    ch_d;
  logic [31:0]   data_d;
  logic          user_d;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  ucc_line #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .cur_hour_i   (s_axis_tdata[12:8]),
    .cur_minute_i (s_axis_tdata[18:13]),
    .cur_second_i (s_axis_tdata[24:19]),
    .job_o        (job_new)
  );

  // sequencing control
  assign out_load  = !out_valid_q || m_axis_tready;
  assign has_cmd   = job_q.cmd != ucc_pkg::CMD_NONE;
  assign last_idx  = !job_q.cr ? 4'd0 : (has_cmd ? 4'd11 : 4'd4);
  assign is_last   = idx_q == last_idx;
  assign job_done  = job_valid_q && out_load && is_last;
  assign s_axis_tready = !job_valid_q || job_done;
  assign tail_pos  = has_cmd ? 2'(idx_q - 4'd8) : 2'(idx_q - 4'd1);

  // digit of the value picked by the character index
  always_comb begin
    case (idx_q[2:1])
      2'd1:    sel_val = job_q.val[0];
      2'd2:    sel_val = job_q.val[1];
      2'd3:    sel_val = job_q.val[2];
      default: sel_val = job_q.val[2];
    endcase
  end
  assign tens  = ucc_pkg::div10(sel_val);
  assign units = ucc_pkg::mod10(sel_val, tens);

  // character for the current index
  always_comb begin
    ch_d = job_q.ch;
    if (idx_q != 4'd0) begin
      if (has_cmd && idx_q == 4'd1) begin
        ch_d = (job_q.cmd == ucc_pkg::CMD_SET) ? ucc_pkg::CharSet : ucc_pkg::CharGet;
      end else if (has_cmd && idx_q < 4'd8) begin
        ch_d = idx_q[0] ? ({4'b0000, units} + ucc_pkg::CharZero)
                        : (8'(tens) + ucc_pkg::CharZero);
      end else begin
        case (tail_pos)
          2'd0:    ch_d = ucc_pkg::CharCr;
          2'd1:    ch_d = ucc_pkg::CharPrmpt;
          2'd2:    ch_d = ucc_pkg::CharPrmpt;
          default: ch_d = ucc_pkg::CharSpace;
        endcase
      end
    end
  end

  // time write flag and values ride on the echo only
  assign user_d = (idx_q == 4'd0) && (job_q.cmd == ucc_pkg::CMD_SET);
  assign data_d = user_d ? {job_q.val[2], job_q.val[1], job_q.val[0], ch_d}
                         : {24'd0, ch_d};

  // job register and character index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else begin
      if (in_accept) begin
        job_valid_q <= 1'b1;
      end else if (job_done) begin
        job_valid_q <= 1'b0;
      end
      if (job_done) begin
        idx_q <= 4'd0;
      end else if (job_valid_q && out_load) begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      job_q <= job_new;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= job_valid_q;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load && job_valid_q) begin
      out_data_q <= data_d;
      out_last_q <= is_last;
      out_user_q <= user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

@@ rtl/ucc_checker.sv @@
// port-level checks for the clock command console, bound to the top level
`default_nettype none

module ucc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // time write is only on the echo of a carriage return
  a_write_on_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h0D)
    else $error("time write not on carriage return echo");

  // a set command always has more characters after the echo
  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("time write on final character");

  // new values are zero outside a time write
  a_values_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:8] == 24'd0)
    else $error("time values set without time write");

  // a carriage return is never the final character of a run
  a_cr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] != 8'h0D)
    else $error("run ends on carriage return");

endmodule

bind uart_clock_command_console ucc_checker u_ucc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
